@@ design/qsub_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsub_pkg
// Shared constants and fixed-point helpers for the quantized int8 subtract.
// ----------------------------------------------------------------------------
package qsub_pkg;

  // register map, index = paddr[4:2]
  localparam int AddrWidth = 5;
  localparam logic [2:0] REG_A_OFFSET   = 3'd0;
  localparam logic [2:0] REG_B_OFFSET   = 3'd1;
  localparam logic [2:0] REG_OUT_OFFSET = 3'd2;
  localparam logic [2:0] REG_A_MULT     = 3'd3;
  localparam logic [2:0] REG_B_MULT     = 3'd4;
  localparam logic [2:0] REG_OUT_MULT   = 3'd5;
  localparam logic [2:0] REG_SHIFTS     = 3'd6;
  localparam logic [2:0] REG_BOUNDS     = 3'd7;

  // pipeline depth, one register per datapath stage
  localparam int Stages = 9;

  // reset values
  localparam logic [30:0] MULT_RESET   = 31'h4000_0000;
  localparam logic [15:0] BOUNDS_RESET = 16'h7F80;

  // doubling high multiply finish: (p + nudge) / 2^31, truncated toward zero
  function automatic logic [31:0] high_mul_round(input logic [63:0] prod);
    logic [63:0] nudge;
    logic [63:0] sum;
    logic [31:0] q;
    nudge = prod[63] ? 64'hFFFF_FFFF_C000_0001 : 64'h0000_0000_4000_0000;
    sum   = prod + nudge;
    q     = sum[62:31];
    if (sum[63] && (sum[30:0] != 31'd0)) begin
      q = q + 32'd1;
    end
    return q;
  endfunction

  // rounding divide by 2^e, half away from zero
  function automatic logic [31:0] round_shift(input logic [31:0] x, input logic [4:0] e);
    logic [31:0] mask;
    logic [31:0] rem;
    logic [31:0] thr;
    logic [31:0] q;
    mask = (32'd1 << e) - 32'd1;
    rem  = x & mask;
    thr  = (mask >> 1) + {31'd0, x[31]};
    q    = $signed(x) >>> e;
    if (rem > thr) begin
      q = q + 32'd1;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

@@ design/quantized_int8_elementwise_sub_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quantized_int8_elementwise_sub_core
// Streaming int8 subtract with per-operand and output fixed-point rescale.
//
// Usage:
//   Operand words (operand_a, operand_b, last_in) enter on the
//   operand_valid / operand_ready handshake, result words (difference,
//   last_out) leave on result_valid / result_ready. last_out follows
//   last_in of the same word.
//   Nine register stages: offset add and left shift, 32x32 multiply,
//   high-half rounding, rounding right shift, subtract and left shift,
//   output multiply, high-half rounding, rounding right shift, offset add
//   and clamp. Throughput is one word per cycle while result_ready
//   stays high; the three 32x32 multipliers per lane each take one stage.
//   When result_ready is low, stages stall from the output backward; empty
//   stages keep filling, so operand_ready drops only when every stage
//   ahead is occupied.
//   Synchronous reset empties the pipeline and loads register defaults:
//   offsets 0, multipliers 2^30, shifts 0, bounds -128..127.
//   Registers are written through the APB port and should change only
//   while the pipeline is empty.
// ----------------------------------------------------------------------------
module quantized_int8_elementwise_sub_core (
  input  wire                            clk,
  input  wire                            rst,
  // apb configuration
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [qsub_pkg::AddrWidth-1:0]  paddr,
  input  wire [31:0]                     pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // operand channel
  input  wire                            operand_valid,
  output logic                           operand_ready,
  input  wire signed [7:0]               operand_a,
  input  wire signed [7:0]               operand_b,
  input  wire                            last_in,
  // result channel
  output logic                           result_valid,
  input  wire                            result_ready,
  output logic signed [7:0]              difference,
  output logic                           last_out
);
  import qsub_pkg::*;

  // configuration registers
  logic [8:0]  a_offset;
  logic [8:0]  b_offset;
  logic [7:0]  out_offset;
  logic [30:0] a_mult;
  logic [30:0] b_mult;
  logic [30:0] out_mult;
  logic [29:0] shifts;
  logic [15:0] bounds;

  logic [2:0] reg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      a_offset   <= 9'd0;
      b_offset   <= 9'd0;
      out_offset <= 8'd0;
      a_mult     <= MULT_RESET;
      b_mult     <= MULT_RESET;
      out_mult   <= MULT_RESET;
      shifts     <= 30'd0;
      bounds     <= BOUNDS_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_A_OFFSET:   a_offset   <= pwdata[8:0];
        REG_B_OFFSET:   b_offset   <= pwdata[8:0];
        REG_OUT_OFFSET: out_offset <= pwdata[7:0];
        REG_A_MULT:     a_mult     <= pwdata[30:0];
        REG_B_MULT:     b_mult     <= pwdata[30:0];
        REG_OUT_MULT:   out_mult   <= pwdata[30:0];
        REG_SHIFTS:     shifts     <= pwdata[29:0];
        REG_BOUNDS:     bounds     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_index)
      REG_A_OFFSET:   prdata = {23'd0, a_offset};
      REG_B_OFFSET:   prdata = {23'd0, b_offset};
      REG_OUT_OFFSET: prdata = {24'd0, out_offset};
      REG_A_MULT:     prdata = {1'b0, a_mult};
      REG_B_MULT:     prdata = {1'b0, b_mult};
      REG_OUT_MULT:   prdata = {1'b0, out_mult};
      REG_SHIFTS:     prdata = {2'd0, shifts};
      REG_BOUNDS:     prdata = {16'd0, bounds};
      default:        prdata = 32'd0;
    endcase
  end

  // shift fields
  logic [4:0] lsh_a, lsh_b, lsh_out, rsh_a, rsh_b, rsh_out;
  assign lsh_a   = shifts[4:0];
  assign lsh_b   = shifts[9:5];
  assign lsh_out = shifts[14:10];
  assign rsh_a   = shifts[19:15];
  assign rsh_b   = shifts[24:20];
  assign rsh_out = shifts[29:25];

  // stage valids and advance enables, collapsing bubbles
  logic [Stages-1:0] vld;
  logic [Stages-1:0] last;
  logic [Stages-1:0] en;

  always_comb begin
    en[Stages-1] = !vld[Stages-1] || result_ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign operand_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= operand_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // end-of-tensor mark rides along
  always_ff @(posedge clk) begin
    if (en[0]) begin
      last[0] <= last_in;
    end
    for (int k = 1; k < Stages; k++) begin
      if (en[k]) begin
        last[k] <= last[k-1];
      end
    end
  end

  // stage 0: offset add and wrapping left shift
  logic [9:0]  sum_a, sum_b;
  logic [31:0] shl_a, shl_b;
  assign sum_a = {{2{operand_a[7]}}, operand_a} + {a_offset[8], a_offset};
  assign sum_b = {{2{operand_b[7]}}, operand_b} + {b_offset[8], b_offset};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      shl_a <= {{22{sum_a[9]}}, sum_a} << lsh_a;
      shl_b <= {{22{sum_b[9]}}, sum_b} << lsh_b;
    end
  end

  // stage 1: operand multiplies
  logic [63:0] prod_a, prod_b;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_a <= 64'($signed(shl_a) * $signed({1'b0, a_mult}));
      prod_b <= 64'($signed(shl_b) * $signed({1'b0, b_mult}));
    end
  end

  // stage 2: rounded high half
  logic [31:0] high_a, high_b;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      high_a <= high_mul_round(prod_a);
      high_b <= high_mul_round(prod_b);
    end
  end

  // stage 3: rounding right shift
  logic [31:0] scaled_a, scaled_b;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      scaled_a <= round_shift(high_a, rsh_a);
      scaled_b <= round_shift(high_b, rsh_b);
    end
  end

  // stage 4: subtract and wrapping left shift
  logic [31:0] diff_shl;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      diff_shl <= (scaled_a - scaled_b) << lsh_out;
    end
  end

  // stage 5: output multiply
  logic [63:0] prod_out;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      prod_out <= 64'($signed(diff_shl) * $signed({1'b0, out_mult}));
    end
  end

  // stage 6: rounded high half
  logic [31:0] high_out;
  always_ff @(posedge clk) begin
    if (en[6]) begin
      high_out <= high_mul_round(prod_out);
    end
  end

  // stage 7: rounding right shift
  logic [31:0] scaled_out;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      scaled_out <= round_shift(high_out, rsh_out);
    end
  end

  // stage 8: output offset and clamp, max first then min
  logic signed [32:0] offs_sum;
  logic signed [32:0] clamp_max, clamp_min;
  logic signed [32:0] clamped;
  logic [7:0]         result_word;

  assign offs_sum  = $signed({scaled_out[31], scaled_out})
                   + $signed({{25{out_offset[7]}}, out_offset});
  assign clamp_min = $signed({{25{bounds[7]}}, bounds[7:0]});
  assign clamp_max = $signed({{25{bounds[15]}}, bounds[15:8]});

  always_comb begin
    clamped = offs_sum;
    if (clamped > clamp_max) begin
      clamped = clamp_max;
    end
    if (clamped < clamp_min) begin
      clamped = clamp_min;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      result_word <= clamped[7:0];
    end
  end

  assign result_valid = vld[Stages-1];
  assign difference   = $signed(result_word);
  assign last_out     = last[Stages-1];

  // a fully occupied, stalled pipe refuses new words
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !result_ready) |-> !operand_ready)
    else $error("operand accepted into a full stalled pipeline");

  // an empty first stage always takes a word
  a_head_open: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> operand_ready)
    else $error("empty first stage not ready");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !vld[Stages-2]) |=> !result_valid)
    else $error("result repeated after it was taken");

  // a held middle stage keeps its word
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !en[4]) |=> (vld[4] && $stable(diff_shl)))
    else $error("stalled stage lost or changed its word");

endmodule
`default_nettype wire
